### sv/gsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared constants, mode codes and control structs for the generational
// slot pool.
// ----------------------------------------------------------------------------
package gsp_pkg;

    localparam int SLOTS_DEFAULT = 64;
    localparam int IMG_W         = 41;
    localparam int MODE_W        = 2;
    localparam int IN_IDX_W      = 8;
    localparam int GEN_W         = 32;
    localparam int OUT_IDX_W     = 6;
    localparam int OFF_W         = 46;
    localparam int CNT_OUT_W     = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_VIEW    = 2'd2
    } mode_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_op_t;

    typedef struct packed {
        logic alloc;
        logic release_slot;
    } slot_op_t;

endpackage
`default_nettype wire

### sv/gsp_free_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_free_stack
// Free-slot stack. Entries carry slot index and current generation. The top
// entry is held in a register, refilled from memory each cycle at the next
// top address; a push bypasses straight into it.
// ----------------------------------------------------------------------------
module gsp_free_stack import gsp_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire stack_op_t                                    op,
    input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] push_idx,
    input  wire logic [GEN_W-1:0]                             push_gen,
    output logic      [$clog2(SLOTS + 1)-1:0]                 free_top,
    output logic      [$clog2(SLOTS + 1)-1:0]                 free_top_next,
    output logic      [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] top_idx,
    output logic      [GEN_W-1:0]                             top_gen
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int ENT_W = IDX_W + GEN_W;

    logic [ENT_W-1:0] stack_mem [SLOTS];
    logic [SLOTS-1:0] stack_valid_reg;
    logic [ENT_W-1:0] top_reg;
    logic [CNT_W-1:0] free_top_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] push_entry;
    logic [ENT_W-1:0] init_entry;

    assign push_entry = {push_idx, push_gen};
    assign wr_addr    = IDX_W'(free_top_reg);
    assign init_entry = {IDX_W'(SLOTS - 1) - rd_addr, GEN_W'(0)};

    always_comb
    begin
        if (op.push)
        begin
            free_top_next = free_top_reg + CNT_W'(1);
        end
        else if (op.pop)
        begin
            free_top_next = free_top_reg - CNT_W'(1);
        end
        else
        begin
            free_top_next = free_top_reg;
        end
    end

    assign rd_addr = (free_top_next == '0) ? '0 : IDX_W'(free_top_next - CNT_W'(1));

    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            stack_mem[wr_addr] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_valid_reg <= '0;
            free_top_reg    <= CNT_W'(SLOTS);
            top_reg         <= '0;
        end
        else
        begin
            free_top_reg <= free_top_next;
            if (op.push)
            begin
                stack_valid_reg[wr_addr] <= 1'b1;
                top_reg                  <= push_entry;
            end
            else if (stack_valid_reg[rd_addr])
            begin
                top_reg <= stack_mem[rd_addr];
            end
            else
            begin
                top_reg <= init_entry;
            end
        end
    end

    assign free_top = free_top_reg;
    assign top_idx  = top_reg[ENT_W-1:GEN_W];
    assign top_gen  = top_reg[GEN_W-1:0];

endmodule
`default_nettype wire

### sv/gsp_slot_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsp_slot_table
// Per-slot busy flags and generation memory. The generation is read when an
// item is accepted, with bypass of a release committing on the same edge.
// ----------------------------------------------------------------------------
module gsp_slot_table import gsp_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         rd_en,
    input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
    input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] chk_addr,
    input  wire slot_op_t                                     op,
    input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] alloc_addr,
    input  wire logic [GEN_W-1:0]                             gen_wr_data,
    output logic      [GEN_W-1:0]                             gen_rd,
    output logic                                              busy_rd
);

    logic [GEN_W-1:0] gen_mem [SLOTS];
    logic [SLOTS-1:0] gen_valid_reg;
    logic [SLOTS-1:0] busy_reg;
    logic [GEN_W-1:0] gen_rd_reg;

    always_ff @(posedge clk)
    begin
        if (op.release_slot)
        begin
            gen_mem[chk_addr] <= gen_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (op.release_slot && (chk_addr == rd_addr))
            begin
                gen_rd_reg <= gen_wr_data;
            end
            else if (gen_valid_reg[rd_addr])
            begin
                gen_rd_reg <= gen_mem[rd_addr];
            end
            else
            begin
                gen_rd_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_valid_reg <= '0;
            busy_reg      <= '0;
        end
        else
        begin
            if (op.release_slot)
            begin
                gen_valid_reg[chk_addr] <= 1'b1;
                busy_reg[chk_addr]      <= 1'b0;
            end
            if (op.alloc)
            begin
                busy_reg[alloc_addr] <= 1'b1;
            end
        end
    end

    assign gen_rd  = gen_rd_reg;
    assign busy_rd = busy_reg[chk_addr];

endmodule
`default_nettype wire

### sv/generational_slot_pool.sv
`default_nettype none
// Path: input beat to result beat through the input register, then the
//   result register.
// Throughput: one item per cycle while the result is not stalled; set by the
//   stack top refill and generation lookup.
// Reset: free stack returns slot 0 first, all generations zero, busy count
//   clear; no clearing pass, items are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
// generational_slot_pool
// Slot pool handing out index plus generation handles: allocate, release and
// view with stale-handle detection and slot byte offset.
// ----------------------------------------------------------------------------
module generational_slot_pool import gsp_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [IMG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [MODE_W-1:0]    mode,
    input  wire logic [IN_IDX_W-1:0]  slot_index,
    input  wire logic [GEN_W-1:0]     generation,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      ok,
    output logic [OUT_IDX_W-1:0]      handle_index,
    output logic [GEN_W-1:0]          handle_generation,
    output logic [OFF_W-1:0]          slot_offset,
    output logic [CNT_OUT_W-1:0]      free_slots,
    output logic [CNT_OUT_W-1:0]      busy_slots
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CMP_W  = IN_IDX_W + 1;
    localparam int PROD_W = IN_IDX_W + IMG_W;

    logic [IMG_W-1:0]    img_reg;

    logic                s1_valid_reg;
    logic [MODE_W-1:0]   s1_mode_reg;
    logic [IN_IDX_W-1:0] s1_idx_reg;
    logic [GEN_W-1:0]    s1_gen_reg;

    logic                out_valid_reg;
    logic                ok_reg;
    logic [OUT_IDX_W-1:0] hidx_reg;
    logic [GEN_W-1:0]    hgen_reg;
    logic [OFF_W-1:0]    off_reg;
    logic [CNT_OUT_W-1:0] free_reg;
    logic [CNT_OUT_W-1:0] busy_out_reg;

    logic [CNT_W-1:0]    busy_count_reg;
    logic [CNT_W-1:0]    busy_count_next;

    logic                fire;
    logic                accept;
    logic [IDX_W-1:0]    tbl_addr;
    logic                in_range;
    logic                hit;
    logic [GEN_W-1:0]    gen_rd;
    logic                busy_rd;
    logic [GEN_W-1:0]    gen_bumped;
    logic [PROD_W-1:0]   prod;

    stack_op_t           stack_op;
    slot_op_t            slot_op;
    logic [CNT_W-1:0]    free_top;
    logic [CNT_W-1:0]    free_top_next;
    logic [IDX_W-1:0]    top_idx;
    logic [GEN_W-1:0]    top_gen;

    logic                r_ok;
    logic [IDX_W-1:0]    r_idx;
    logic [GEN_W-1:0]    r_gen;
    logic [OFF_W-1:0]    r_off;

    logic [OUT_IDX_W+IDX_W-1:0] r_idx_ext;
    logic [CNT_OUT_W+CNT_W-1:0] free_ext;
    logic [CNT_OUT_W+CNT_W-1:0] busy_ext;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_reg <= '0;
        end
        else if (cfg_valid)
        begin
            img_reg <= cfg_data;
        end
    end

    // handshake
    assign fire     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= mode;
            s1_idx_reg  <= slot_index;
            s1_gen_reg  <= generation;
        end
    end

    // execute
    assign tbl_addr   = s1_idx_reg[IDX_W-1:0];
    assign in_range   = CMP_W'(s1_idx_reg) < CMP_W'(SLOTS);
    assign hit        = in_range && busy_rd && (gen_rd == s1_gen_reg);
    assign gen_bumped = (gen_rd == '1) ? GEN_W'(1) : gen_rd + GEN_W'(1);
    assign prod       = PROD_W'(s1_idx_reg) * PROD_W'(img_reg);

    always_comb
    begin
        stack_op        = '0;
        slot_op         = '0;
        r_ok            = 1'b0;
        r_idx           = '0;
        r_gen           = '0;
        r_off           = '0;
        busy_count_next = busy_count_reg;
        unique case (mode_t'(s1_mode_reg))
            MODE_ALLOC:
            begin
                if (free_top != '0)
                begin
                    stack_op.pop    = fire;
                    slot_op.alloc   = fire;
                    r_ok            = 1'b1;
                    r_idx           = top_idx;
                    r_gen           = top_gen;
                    busy_count_next = busy_count_reg + CNT_W'(1);
                end
            end
            MODE_RELEASE:
            begin
                if (hit && (free_top < CNT_W'(SLOTS)))
                begin
                    stack_op.push        = fire;
                    slot_op.release_slot = fire;
                    r_ok                 = 1'b1;
                    r_idx                = tbl_addr;
                    r_gen                = s1_gen_reg;
                    if (busy_count_reg != '0)
                    begin
                        busy_count_next = busy_count_reg - CNT_W'(1);
                    end
                end
            end
            MODE_VIEW:
            begin
                if (hit)
                begin
                    r_ok  = 1'b1;
                    r_idx = tbl_addr;
                    r_gen = s1_gen_reg;
                    r_off = prod[OFF_W-1:0];
                end
            end
            default:
            begin
                r_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_count_reg <= '0;
        end
        else if (fire)
        begin
            busy_count_reg <= busy_count_next;
        end
    end

    gsp_free_stack #(
        .SLOTS (SLOTS)
    ) u_stack (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (stack_op),
        .push_idx      (tbl_addr),
        .push_gen      (gen_bumped),
        .free_top      (free_top),
        .free_top_next (free_top_next),
        .top_idx       (top_idx),
        .top_gen       (top_gen)
    );

    gsp_slot_table #(
        .SLOTS (SLOTS)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (accept),
        .rd_addr     (slot_index[IDX_W-1:0]),
        .chk_addr    (tbl_addr),
        .op          (slot_op),
        .alloc_addr  (top_idx),
        .gen_wr_data (gen_bumped),
        .gen_rd      (gen_rd),
        .busy_rd     (busy_rd)
    );

    // result register
    assign r_idx_ext = {OUT_IDX_W'(0), r_idx};
    assign free_ext  = {CNT_OUT_W'(0), free_top_next};
    assign busy_ext  = {CNT_OUT_W'(0), busy_count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ok_reg       <= r_ok;
            hidx_reg     <= r_idx_ext[OUT_IDX_W-1:0];
            hgen_reg     <= r_gen;
            off_reg      <= r_off;
            free_reg     <= free_ext[CNT_OUT_W-1:0];
            busy_out_reg <= busy_ext[CNT_OUT_W-1:0];
        end
    end

    assign out_valid         = out_valid_reg;
    assign ok                = ok_reg;
    assign handle_index      = hidx_reg;
    assign handle_generation = hgen_reg;
    assign slot_offset       = off_reg;
    assign free_slots        = free_reg;
    assign busy_slots        = busy_out_reg;

`ifndef SYNTHESIS
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W + 1)'(free_top) + (CNT_W + 1)'(busy_count_reg) == (CNT_W + 1)'(SLOTS))
        else $error("free and busy counts do not add up to the pool size");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !ok_reg |->
            handle_index == '0 && handle_generation == '0 && slot_offset == '0)
        else $error("failed beat carries nonzero handle or offset");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall)
        else $error("input stalled without a stalled result");

    a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        stack_op.push |-> gen_bumped != '0)
        else $error("released slot pushed with generation zero");

    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(stack_op.push && stack_op.pop))
        else $error("push and pop in the same cycle");
`endif

endmodule
`default_nettype wire
